// ----- rtl/lpr_pkg.sv -----
// Shared types and constants of the line pixel rasteriser.
package lpr_pkg;

    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_X  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_Y  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND_X = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND_Y = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CHECK  = 4'b0010,
        S_DSTART = 4'b0100,
        S_DIV    = 4'b1000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic step;
        logic restart;
        logic mul;
        logic div_start;
        logic resync;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic q_full;
        logic adv_ok;
        logic div_busy;
    } t_status;

endpackage

// ----- rtl/lpr_in_if.sv -----
// Input channel of the line pixel rasteriser: one beat per step request.
interface lpr_in_if;
    logic valid;
    logic ready;
    logic begin_line;

    modport source (output valid, output begin_line, input ready);
    modport sink (input valid, input begin_line, output ready);
endinterface

// ----- rtl/lpr_out_if.sv -----
// Output channel of the line pixel rasteriser: one beat per pixel result.
interface lpr_out_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  drawn;
    logic                  on_screen;
    logic                  last_pixel;
    logic                  line_ok;

    modport source (output valid, output pixel_x, output pixel_y, output drawn,
                    output on_screen, output last_pixel, output line_ok, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input drawn,
                  input on_screen, input last_pixel, input line_ok, output ready);
endinterface

// ----- rtl/lpr_div.sv -----
// Restoring divider, one quotient bit per cycle, for re-deriving the minor coordinate.
module lpr_div #(
    parameter int COORD_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [2*COORD_BITS+1:0] i_num,
    input  logic [COORD_BITS:0]     i_den,
    output logic                    o_busy,
    output logic [COORD_BITS-1:0]   o_quo,
    output logic [COORD_BITS:0]     o_rem
);
    localparam int CB = COORD_BITS;
    localparam int MW = 2 * CB + 2;
    localparam int CW = $clog2(CB);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [CB:0]   r_rem;
    logic [CB-1:0] r_low;
    logic [CB-1:0] r_quo;

    logic [CB+1:0] trial;
    logic [CB+1:0] diff;
    logic          ge;

    // The quotient is known to fit in CB bits, so the top of the numerator
    // already lies below the divisor and only CB bits remain to be shifted in.
    assign trial = {r_rem, r_low[CB-1]};
    assign ge    = trial >= {1'b0, i_den};
    assign diff  = trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(CB - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[MW-2:CB];
            r_low <= i_num[CB-1:0];
        end else if (r_busy) begin
            r_rem <= ge ? diff[CB:0] : trial[CB:0];
            r_low <= {r_low[CB-2:0], 1'b0};
            r_quo <= {r_quo[CB-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/lpr_datapath.sv -----
// Datapath: endpoint registers, line geometry, pixel stepping and the result queue.
module lpr_datapath #(
    parameter int COORD_BITS    = 12,
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lpr_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [COORD_BITS-1:0]             i_cfg_data,
    input  lpr_pkg::t_cmd                     i_cmd,
    output lpr_pkg::t_status                  o_st,
    lpr_out_if.source                         o_pixel
);
    import lpr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int MW = 2 * CB + 2;
    localparam int RW = 2 * CB + 4;

    // Endpoint registers.
    logic [CB-1:0] r_first_x, r_first_y, r_second_x, r_second_y;

    // Geometry, recomputed from the endpoints and registered every cycle.
    logic          swap;
    logic [CB-1:0] lx, ly, hx, hy;
    logic [CB:0]   dx_full, dy, ady_full;
    logic [CB-1:0] dx_u, ady_u;
    logic          g_vert, g_neg, g_degen;
    logic [CB-1:0] g_major0, g_minor0, g_dmajor, g_mag;

    logic          r_g_vert, r_g_neg, r_g_degen;
    logic [CB-1:0] r_g_major0, r_g_minor0, r_g_dmajor, r_g_mag;

    // Line walk state.
    logic          r_active, n_active;
    logic          r_all_on, n_all_on;
    logic [CB:0]   r_k, n_k;
    logic [CB-1:0] r_major, n_major;
    logic [CB-1:0] r_minor, n_minor;
    logic [CB:0]   r_rem, n_rem;

    logic [MW-1:0]   r_num;
    logic [2*CB-1:0] prod;
    logic [MW-1:0]   num;

    logic [CB:0]   den;
    logic [CB+1:0] k1;
    logic          adv_ok;
    logic          div_busy;
    logic [CB-1:0] quo;
    logic [CB:0]   drem;

    logic [CB+1:0] radd;
    logic [CB+1:0] rsub;
    logic          carry;
    logic [CB:0]   inc_rem;
    logic [CB-1:0] inc_minor, inc_major;
    logic [CB-1:0] rs_minor, rs_major;
    logic [CB:0]   b_rem;

    logic          produce, restart_all, sel_last;
    logic [CB:0]   sel_k;
    logic [CB-1:0] sel_major, sel_minor;
    logic [CB:0]   sel_rem;
    logic [CB-1:0] pix_x, pix_y;
    logic          pix_on;

    logic          push, pop;
    logic [RW-1:0] res;
    logic          r_hv, n_hv, r_tv, n_tv;
    logic [RW-1:0] r_head, n_head, r_tail, n_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_x  <= '0;
            r_first_y  <= '0;
            r_second_x <= '0;
            r_second_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_X:  r_first_x  <= i_cfg_data;
                CFG_FIRST_Y:  r_first_y  <= i_cfg_data;
                CFG_SECOND_X: r_second_x <= i_cfg_data;
                CFG_SECOND_Y: r_second_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        swap     = $signed(r_first_x) > $signed(r_second_x);
        lx       = swap ? r_second_x : r_first_x;
        ly       = swap ? r_second_y : r_first_y;
        hx       = swap ? r_first_x  : r_second_x;
        hy       = swap ? r_first_y  : r_second_y;
        dx_full  = {hx[CB-1], hx} - {lx[CB-1], lx};
        dy       = {hy[CB-1], hy} - {ly[CB-1], ly};
        ady_full = dy[CB] ? (~dy + 1'b1) : dy;
        dx_u     = dx_full[CB-1:0];
        ady_u    = ady_full[CB-1:0];
        g_degen  = (r_first_x == r_second_x) && (r_first_y == r_second_y);
        g_vert   = ady_u > dx_u;
        if (g_vert) begin
            // Steep line: walk up in y from the lower endpoint.
            g_major0 = dy[CB] ? hy : ly;
            g_minor0 = dy[CB] ? hx : lx;
            g_dmajor = ady_u;
            g_mag    = dx_u;
            g_neg    = dy[CB];
        end else begin
            g_major0 = lx;
            g_minor0 = ly;
            g_dmajor = dx_u;
            g_mag    = ady_u;
            g_neg    = dy[CB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_vert   <= g_vert;
        r_g_neg    <= g_neg;
        r_g_degen  <= g_degen;
        r_g_major0 <= g_major0;
        r_g_minor0 <= g_minor0;
        r_g_dmajor <= g_dmajor;
        r_g_mag    <= g_mag;
    end

    assign den    = {r_g_dmajor, 1'b0};
    assign k1     = {1'b0, r_k} + (CB+2)'(1);
    assign adv_ok = r_active && !r_g_degen && (k1 <= {2'b00, r_g_dmajor});

    // Numerator of the minor offset at step k+1, for re-deriving after an endpoint change.
    assign prod = {{CB{1'b0}}, r_g_mag} * {{CB{1'b0}}, k1[CB-1:0]};
    assign num  = {1'b0, prod, 1'b0} + ((r_g_mag != '0) ? MW'(r_g_dmajor) : MW'(0));

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_num <= num;
        end
    end

    lpr_div #(
        .COORD_BITS (CB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (den),
        .o_busy  (div_busy),
        .o_quo   (quo),
        .o_rem   (drem)
    );

    // Incremental step: the remainder grows by twice the minor extent and
    // wraps at most once, moving the minor coordinate by one.
    assign radd      = {1'b0, r_rem} + {1'b0, r_g_mag, 1'b0};
    assign carry     = radd >= {1'b0, den};
    assign rsub      = radd - {1'b0, den};
    assign inc_rem   = carry ? rsub[CB:0] : radd[CB:0];
    assign inc_minor = carry ? (r_g_neg ? r_minor - CB'(1) : r_minor + CB'(1)) : r_minor;
    assign inc_major = r_major + CB'(1);
    assign rs_minor  = r_g_neg ? r_g_minor0 - quo : r_g_minor0 + quo;
    assign rs_major  = r_g_major0 + k1[CB-1:0];
    assign b_rem     = (r_g_mag != '0) ? {1'b0, r_g_dmajor} : '0;

    always_comb begin
        n_active    = r_active;
        n_all_on    = r_all_on;
        n_k         = r_k;
        n_major     = r_major;
        n_minor     = r_minor;
        n_rem       = r_rem;
        push        = 1'b0;
        produce     = 1'b0;
        restart_all = 1'b0;
        sel_k       = k1[CB:0];
        sel_major   = inc_major;
        sel_minor   = inc_minor;
        sel_rem     = inc_rem;
        sel_last    = (k1 == {2'b00, r_g_dmajor});
        pix_x       = r_first_x;
        pix_y       = r_first_y;
        pix_on      = 1'b0;
        // The degenerate line result is the default payload.
        res         = {r_first_x, r_first_y, 1'b0, 1'b0, 1'b1, 1'b0};

        if (i_cmd.step && i_cmd.restart) begin
            n_k = '0;
            if (r_g_degen) begin
                n_active = 1'b0;
                n_all_on = 1'b0;
                push     = 1'b1;
            end else begin
                produce     = 1'b1;
                restart_all = 1'b1;
                sel_k       = '0;
                sel_major   = r_g_major0;
                sel_minor   = r_g_minor0;
                sel_rem     = b_rem;
                sel_last    = 1'b0;
            end
        end else if (i_cmd.step && r_active) begin
            if (adv_ok) begin
                produce = 1'b1;
            end else begin
                n_active = 1'b0;
            end
        end else if (i_cmd.resync) begin
            produce   = 1'b1;
            sel_major = rs_major;
            sel_minor = rs_minor;
            sel_rem   = drem;
        end

        if (produce) begin
            pix_x    = r_g_vert ? sel_minor : sel_major;
            pix_y    = r_g_vert ? sel_major : sel_minor;
            pix_on   = !pix_x[CB-1] && !pix_y[CB-1] && (int'(pix_x) < SCREEN_WIDTH)
                       && (int'(pix_y) < SCREEN_HEIGHT);
            n_k      = sel_k;
            n_major  = sel_major;
            n_minor  = sel_minor;
            n_rem    = sel_rem;
            n_all_on = (restart_all || r_all_on) && pix_on;
            n_active = !sel_last;
            push     = 1'b1;
            res      = {pix_x, pix_y, 1'b1, pix_on, sel_last, n_all_on};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_all_on <= 1'b1;
            r_k      <= '0;
        end else begin
            r_active <= n_active;
            r_all_on <= n_all_on;
            r_k      <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_major <= n_major;
        r_minor <= n_minor;
        r_rem   <= n_rem;
    end

    // Two-entry result queue: the head drives the output channel.
    assign pop = r_hv && o_pixel.ready;

    always_comb begin
        n_hv   = r_hv;
        n_tv   = r_tv;
        n_head = r_head;
        n_tail = r_tail;
        if (pop) begin
            n_hv   = r_tv;
            n_head = r_tail;
            n_tv   = 1'b0;
        end
        if (push) begin
            if (!n_hv) begin
                n_hv   = 1'b1;
                n_head = res;
            end else begin
                n_tv   = 1'b1;
                n_tail = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_tv <= 1'b0;
        end else begin
            r_hv <= n_hv;
            r_tv <= n_tv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

    assign o_pixel.valid      = r_hv;
    assign o_pixel.pixel_x    = r_head[RW-1 -: CB];
    assign o_pixel.pixel_y    = r_head[RW-CB-1 -: CB];
    assign o_pixel.drawn      = r_head[3];
    assign o_pixel.on_screen  = r_head[2];
    assign o_pixel.last_pixel = r_head[1];
    assign o_pixel.line_ok    = r_head[0];

    assign o_st.q_full   = r_tv;
    assign o_st.adv_ok   = adv_ok;
    assign o_st.div_busy = div_busy;

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !r_tv)
        else $error("result pushed into a full queue");

    a_tail_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tv |-> r_hv)
        else $error("queue tail valid without a head beat");

    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hv && !o_pixel.ready) |=> (r_hv && $stable(r_head)))
        else $error("waiting pixel beat changed before it was taken");
`endif

endmodule

// ----- rtl/lpr_ctrl.sv -----
// Controller: accepts step beats and sequences the datapath through fast and re-derive paths.
module lpr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    lpr_in_if.sink           i_line,
    input  lpr_pkg::t_status i_st,
    output lpr_pkg::t_cmd    o_cmd
);
    import lpr_pkg::*;

    t_state r_state, n_state;
    logic   r_begin, n_begin;
    logic   r_stale;
    logic   r_resync, n_resync;
    logic   accept;

    assign i_line.ready = (r_state == S_IDLE) && !i_st.q_full;
    assign accept       = i_line.valid && i_line.ready;

    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_begin  = r_begin;
        n_resync = r_resync;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // Geometry is only trusted once the endpoints have settled, and an
                    // advance after an endpoint change has to re-derive its position.
                    if (!r_stale && (i_line.begin_line || !r_resync)) begin
                        o_cmd.step    = 1'b1;
                        o_cmd.restart = i_line.begin_line;
                    end else begin
                        n_begin = i_line.begin_line;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_begin || !i_st.adv_ok) begin
                    o_cmd.step    = 1'b1;
                    o_cmd.restart = r_begin;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_DSTART;
                end
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (!i_st.div_busy) begin
                    o_cmd.resync = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_we) begin
            n_resync = 1'b1;
        end else if ((o_cmd.step && (o_cmd.restart || r_state == S_CHECK)) || o_cmd.resync) begin
            n_resync = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_begin  <= 1'b0;
            r_stale  <= 1'b1;
            r_resync <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_begin  <= n_begin;
            r_stale  <= i_cfg_we;
            r_resync <= n_resync;
        end
    end

`ifndef SYNTHESIS
    a_start_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> $past(o_cmd.mul))
        else $error("divider started without a loaded numerator");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_IDLE) || (r_state == S_CHECK))
        else $error("unexpected state after an accepted beat");

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_st.div_busy |-> !i_line.ready)
        else $error("input ready while the divider is running");
`endif

endmodule

// ----- rtl/line_pixel_rasterizer_unit.sv -----
// Top level of the line pixel rasteriser: controller, datapath and channel ports.
//
//  Port      Dir  Beat contents
//  i_line    in   begin_line: restart the line or advance one pixel
//  o_pixel   out  pixel_x, pixel_y, drawn, on_screen, last_pixel, line_ok
//  i_cfg_*   in   endpoint register write (first_x, first_y, second_x, second_y)
//
// An accepted beat normally steps straight away and its result enters the result queue
// at the accepting edge; a two-entry result queue lets input continue while a result
// waits. A restart accepted in the cycle just after an endpoint write first passes the
// check state, and the first advance after an endpoint write passes the check state and,
// if the line can still move, the divider-start and divide states while the bit-serial
// divider re-derives the minor coordinate. Reset clears the endpoints to zero and ends
// any line; there is no clearing pass. Input is held off while the result queue is full.
module line_pixel_rasterizer_unit #(
    parameter int COORD_BITS    = 12,
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lpr_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COORD_BITS-1:0]            i_cfg_data,
    lpr_in_if.sink                           i_line,
    lpr_out_if.source                        o_pixel
);
    import lpr_pkg::*;

    t_cmd    cmd;
    t_status st;

    lpr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_we (i_cfg_we),
        .i_line   (i_line),
        .i_st     (st),
        .o_cmd    (cmd)
    );

    lpr_datapath #(
        .COORD_BITS    (COORD_BITS),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_st       (st),
        .o_pixel    (o_pixel)
    );

endmodule

// ----- test/line_pixel_rasterizer_unit_test.sv -----
// Self-checking testbench of the line pixel rasteriser, with its own line-stepping predictor.
`timescale 1ns / 100ps

localparam int COORD_BITS    = 12;
localparam int SCREEN_WIDTH  = 640;
localparam int SCREEN_HEIGHT = 480;

typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  drawn;
    logic                  on_screen;
    logic                  last_pixel;
    logic                  line_ok;
} t_pixel;

class line_tracer;
    logic [COORD_BITS-1:0] endpoint [4];
    logic [COORD_BITS:0]   step_count;
    bit                    line_active;
    bit                    all_on_screen;
    bit                    steps_along_y;
    t_pixel                pending_pixels [$];
    int                    mismatch_count;

    function new();
        foreach (endpoint[i]) endpoint[i] = '0;
        step_count     = '0;
        line_active    = 0;
        all_on_screen  = 1;
        steps_along_y  = 0;
        mismatch_count = 0;
    endfunction

    function void write_endpoint(logic [1:0] idx, logic [COORD_BITS-1:0] value);
        endpoint[idx] = value;
    endfunction

    function int pending();
        return pending_pixels.size();
    endfunction

    // Orders the endpoints and picks the major axis; 0 for a single-point line.
    function bit plan_line(output bit vertical, output longint major0, output longint minor0,
                           output longint dmajor, output longint dminor);
        longint ax, ay, bx, by, t;
        ax = $signed(endpoint[lpr_pkg::CFG_FIRST_X]);
        ay = $signed(endpoint[lpr_pkg::CFG_FIRST_Y]);
        bx = $signed(endpoint[lpr_pkg::CFG_SECOND_X]);
        by = $signed(endpoint[lpr_pkg::CFG_SECOND_Y]);
        if (ax > bx) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        if (ax == bx && ay == by) return 0;
        if (by - ay > bx - ax || by - ay < ax - bx) begin
            if (ay > by) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            vertical = 1;
            major0   = ay;
            minor0   = ax;
            dmajor   = by - ay;
            dminor   = bx - ax;
        end else begin
            vertical = 0;
            major0   = ax;
            minor0   = ay;
            dmajor   = bx - ax;
            dminor   = by - ay;
        end
        return 1;
    endfunction

    // Advances the line by one accepted beat; returns 1 when a pixel is due.
    function bit take_step(bit begin_line);
        bit     vertical, on;
        longint major0, minor0, dmajor, dminor, k, sgn, minor, major, px, py;
        t_pixel want;
        if (begin_line) begin
            step_count = '0;
            if (!plan_line(vertical, major0, minor0, dmajor, dminor)) begin
                line_active   = 0;
                all_on_screen = 0;
                want = '{x: endpoint[lpr_pkg::CFG_FIRST_X], y: endpoint[lpr_pkg::CFG_FIRST_Y],
                         drawn: 0, on_screen: 0, last_pixel: 1, line_ok: 0};
                pending_pixels.push_back(want);
                return 1;
            end
            all_on_screen = 1;
            line_active   = 1;
            k = 0;
        end else begin
            if (!line_active) return 0;
            // The geometry always follows the current registers, even mid-line.
            if (!plan_line(vertical, major0, minor0, dmajor, dminor) ||
                    longint'(step_count) + 1 > dmajor) begin
                line_active = 0;
                return 0;
            end
            k = longint'(step_count) + 1;
            step_count = k[COORD_BITS:0];
        end
        steps_along_y = vertical;
        sgn   = (dminor > 0) ? 1 : ((dminor < 0) ? -1 : 0);
        minor = (2 * dminor * k + dmajor * sgn) / (2 * dmajor) + minor0;
        major = major0 + k;
        px = vertical ? minor : major;
        py = vertical ? major : minor;
        on = px >= 0 && px < SCREEN_WIDTH && py >= 0 && py < SCREEN_HEIGHT;
        all_on_screen = all_on_screen && on;
        if (k >= dmajor) line_active = 0;
        want = '{x: px[COORD_BITS-1:0], y: py[COORD_BITS-1:0], drawn: 1, on_screen: on,
                 last_pixel: k >= dmajor, line_ok: all_on_screen};
        pending_pixels.push_back(want);
        return 1;
    endfunction

    function void compare_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function void match_pixel(t_pixel got);
        t_pixel want;
        if (pending_pixels.size() == 0) begin
            $display("%0t: pixel beat with none expected, x=%0d y=%0d", $time,
                     $signed(got.x), $signed(got.y));
            mismatch_count++;
            return;
        end
        want = pending_pixels.pop_front();
        compare_field("pixel_x", int'($signed(want.x)), int'($signed(got.x)));
        compare_field("pixel_y", int'($signed(want.y)), int'($signed(got.y)));
        compare_field("drawn", int'(want.drawn), int'(got.drawn));
        compare_field("on_screen", int'(want.on_screen), int'(got.on_screen));
        compare_field("last_pixel", int'(want.last_pixel), int'(got.last_pixel));
        compare_field("line_ok", int'(want.line_ok), int'(got.line_ok));
    endfunction
endclass

module line_pixel_rasterizer_unit_test;
    import lpr_pkg::*;

    localparam int ITEM_TARGET   = 1150;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 500000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [COORD_BITS-1:0]   i_cfg_data;

    lpr_in_if                            line_ch ();
    lpr_out_if #(.COORD_BITS(COORD_BITS)) pixel_ch ();

    line_pixel_rasterizer_unit #(
        .COORD_BITS   (COORD_BITS),
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_line    (line_ch),
        .o_pixel   (pixel_ch)
    );

    line_tracer tracer = new();
    bit         gaps_on;
    bit         stalls_on;
    int         hold_request;
    int         beats_sent;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [COORD_BITS-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        tracer.write_endpoint(idx, value);
    endtask

    task automatic load_endpoints(input int ax, input int ay, input int bx, input int by);
        write_reg(CFG_FIRST_X, COORD_BITS'(ax));
        write_reg(CFG_FIRST_Y, COORD_BITS'(ay));
        write_reg(CFG_SECOND_X, COORD_BITS'(bx));
        write_reg(CFG_SECOND_Y, COORD_BITS'(by));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_beat(input bit begin_line);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            line_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        line_ch.valid      <= 1'b1;
        line_ch.begin_line <= begin_line;
        do @(posedge i_clk); while (!line_ch.ready);
        void'(tracer.take_step(begin_line));
        beats_sent++;
    endtask

    // Holds input back until every pixel is in, then lets the divider settle.
    task automatic drain();
        line_ch.valid <= 1'b0;
        while (tracer.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic play(input int ax, input int ay, input int bx, input int by,
                        input bit restart, input int advances);
        gaps_on   = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
        load_endpoints(ax, ay, bx, by);
        if (restart) send_beat(1'b1);
        repeat (advances) send_beat(1'b0);
        drain();
    endtask

    function automatic int clamp_coord(int v);
        if (v < -2048) return -2048;
        if (v > 2047) return 2047;
        return v;
    endfunction

    function automatic int distance(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Receiver: random stalls per beat, plus a long hold-off when one is requested.
    initial begin
        int low;
        pixel_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            low = stalls_on ? $urandom_range(0, 5) : 0;
            low += hold_request;
            hold_request = 0;
            if (low > 0) begin
                pixel_ch.ready <= 1'b0;
                repeat (low) @(posedge i_clk);
            end
            pixel_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!pixel_ch.valid);
            tracer.match_pixel('{x: pixel_ch.pixel_x, y: pixel_ch.pixel_y,
                                 drawn: pixel_ch.drawn, on_screen: pixel_ch.on_screen,
                                 last_pixel: pixel_ch.last_pixel, line_ok: pixel_ch.line_ok});
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL line_pixel_rasterizer_unit");
        $finish;
    end

    initial begin
        int  ax, ay, bx, by, dmaj, steps, kind, span, phase;
        bit  near;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_FIRST_X;
        i_cfg_data         <= '0;
        line_ch.valid      <= 1'b0;
        line_ch.begin_line <= 1'b0;
        gaps_on      = 0;
        stalls_on    = 0;
        hold_request = 0;
        beats_sent   = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-point line, then an advance with no line running.
        play(0, 0, 0, 0, 1'b1, 1);
        // Steep line given right to left, one advance past its end.
        play(3, 5, 0, 1, 1'b1, 5);
        // Corner to corner: exact diagonal with dy equal to minus dx.
        play(-2048, 2047, 2047, -2048, 1'b1, 3);
        play(2047, -2048, 2047, -2045, 1'b1, 3);
        // Endpoints rewritten while a line is running: the new geometry takes over, and a
        // single-point rewrite ends the line without a pixel.
        play(630, 470, 645, 478, 1'b1, 2);
        play(100, 100, 100, 120, 1'b0, 2);
        play(7, 7, 7, 7, 1'b0, 1);
        play(7, 7, 7, 7, 1'b1, 0);

        phase = 0;
        while (beats_sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 19);
            near = 1'($urandom_range(0, 1));
            ax = near ? $urandom_range(0, 680) - 20 : $urandom_range(0, 4095) - 2048;
            ay = near ? $urandom_range(0, 520) - 20 : $urandom_range(0, 4095) - 2048;
            if (kind == 0) begin
                bx = ax;
                by = ay;
            end else if (kind == 1) begin
                bx = $urandom_range(0, 4095) - 2048;
                by = $urandom_range(0, 4095) - 2048;
            end else begin
                span = (kind < 4) ? 200 : 12;
                bx = clamp_coord(ax + $urandom_range(0, 2 * span) - span);
                by = clamp_coord(ay + $urandom_range(0, 2 * span) - span);
            end
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            // Now and then the receiver stops for a long while during a long line.
            if (phase % 30 == 2) begin
                ax = clamp_coord(ax);
                bx = clamp_coord(ax + 40);
                by = clamp_coord(ay + $urandom_range(0, 20) - 10);
                if (bx == ax) bx = ax - 40;
                hold_request = 60 + $urandom_range(0, 40);
                gaps_on = 0;
            end
            dmaj  = (distance(ax, bx) > distance(ay, by)) ? distance(ax, bx) : distance(ay, by);
            steps = (dmaj > 40) ? $urandom_range(1, 40) : dmaj;
            load_endpoints(ax, ay, bx, by);
            if ($urandom_range(0, 4) != 0) send_beat(1'b1);
            repeat (steps) send_beat($urandom_range(0, 24) == 0);
            repeat ($urandom_range(0, 2)) send_beat(1'b0);
            if ($urandom_range(0, 9) == 0) repeat (8) send_beat(1'($urandom_range(0, 1)));
            drain();
            phase++;
        end

        if (tracer.mismatch_count == 0 && tracer.pending() == 0) begin
            $display("PASS line_pixel_rasterizer_unit");
        end else begin
            $display("FAIL line_pixel_rasterizer_unit");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/lpr_pkg.sv
rtl/lpr_in_if.sv
rtl/lpr_out_if.sv
rtl/lpr_div.sv
rtl/lpr_datapath.sv
rtl/lpr_ctrl.sv
rtl/line_pixel_rasterizer_unit.sv
test/line_pixel_rasterizer_unit_test.sv
